// ===== src/gyro_bias_tracking_yaw_integrator_macros.svh =====
// Assertion macros used by the checker file gbt_yaw_chk.sv.
`ifndef GYRO_BIAS_TRACKING_YAW_INTEGRATOR_MACROS_SVH
`define GYRO_BIAS_TRACKING_YAW_INTEGRATOR_MACROS_SVH

// Checked only while the block is out of reset.
`define GBT_YAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define GBT_YAW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/gbt_yaw_pkg.sv =====
`timescale 1ns / 1ps

package gbt_yaw_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegBiasAlpha = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRateGain  = 1'b1;

  localparam logic [15:0] BiasAlphaRst = 16'd655;
  localparam logic [31:0] RateGainRst  = 32'd391148512;

  // shared multiplier: signed A times zero-extended 16-bit B
  localparam int unsigned MulAW  = 49;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned ProdW  = 67;

  typedef enum logic [2:0] {
    StIdle,
    StBiasMul,
    StBiasAdd,
    StCorr,
    StMulDt,
    StMulGl,
    StMulGh,
    StSum
  } state_e;

endpackage

// ===== src/gyro_bias_tracking_yaw_integrator.sv =====
`timescale 1ns / 1ps
// Gyro yaw integrator with stationary bias tracking.
// Input channel (s_axis): one gyro transaction carries the signed Z-axis sample and the
// elapsed time in microseconds in tdata, and the stationary flag in tuser.
// Output channel (m_axis): one result transaction per input, tdata holds the yaw angle,
// the corrected rate and the bias estimate.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0: bias_alpha,
// 1: rate_gain); write only while no transaction is in flight.
// Every product goes through one shared 49x18 multiplier under a small sequencer, and
// s_axis_tready_o is high only while the sequencer waits for an item.
// With the stationary flag set, the bias multiply and update come first; then the rate is
// corrected, scaled by dt and the gain, and summed. A new item waits until the last is summed.
// The result sits in an output register; if the receiver stalls, the next item is still
// accepted and worked on, and its last step holds until the held result is taken.
// Reset clears bias and heading to zero and loads the default gains; no output is valid.
module gyro_bias_tracking_yaw_integrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gbt_yaw_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gbt_yaw_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [31:0]                         s_axis_tdata_i,  // gyro_sample, dt_us
  input  logic                                s_axis_tuser_i,  // stationary
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [95:0]                         m_axis_tdata_o   // yaw_angle, corrected_rate,
                                                               // bias_estimate
);

  gbt_yaw_pkg::state_e state_q, state_d;

  logic [15:0] alpha_q;
  logic [31:0] gain_q;
  logic [31:0] bias_q;
  logic [31:0] heading_q;

  logic [15:0] sample_q;
  logic [15:0] dt_q;
  logic [31:0] corr_q;
  logic signed [47:0] p_q;

  logic signed [gbt_yaw_pkg::ProdW-1:0] prod_q;
  logic signed [gbt_yaw_pkg::ProdW-1:0] acc_q;

  logic signed [gbt_yaw_pkg::MulAW-1:0] mul_a;
  logic signed [gbt_yaw_pkg::MulBW-1:0] mul_b;
  logic signed [gbt_yaw_pkg::ProdW-1:0] mul_p;

  logic        out_valid_q;
  logic [95:0] out_data_q;

  logic        in_take;
  logic        sum_go;
  logic signed [32:0] diff;
  logic [31:0] corr_sat;
  logic signed [gbt_yaw_pkg::ProdW-1:0] sum;
  logic [31:0] inc;

  assign in_take = s_axis_tvalid_i && s_axis_tready_o;
  assign sum_go  = !out_valid_q || m_axis_tready_i;

  // sample in Q16.16 minus bias; shared by bias update and correction
  assign diff = $signed({sample_q[15], sample_q, 16'h0000}) - $signed({bias_q[31], bias_q});

  always_comb begin
    if (diff[32] != diff[31]) begin
      corr_sat = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      corr_sat = diff[31:0];
    end
  end

  assign mul_p = mul_a * mul_b;

  // floor((p*gh + floor(p*gl / 2^16)) / 2^32), low 32 bits for modulo add
  assign sum = prod_q + (acc_q >>> 16);
  assign inc = sum[63:32];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbt_yaw_pkg::StIdle: begin
        if (in_take) begin
          state_d = s_axis_tuser_i ? gbt_yaw_pkg::StBiasMul : gbt_yaw_pkg::StCorr;
        end
      end
      gbt_yaw_pkg::StBiasMul: state_d = gbt_yaw_pkg::StBiasAdd;
      gbt_yaw_pkg::StBiasAdd: state_d = gbt_yaw_pkg::StCorr;
      gbt_yaw_pkg::StCorr:    state_d = gbt_yaw_pkg::StMulDt;
      gbt_yaw_pkg::StMulDt:   state_d = gbt_yaw_pkg::StMulGl;
      gbt_yaw_pkg::StMulGl:   state_d = gbt_yaw_pkg::StMulGh;
      gbt_yaw_pkg::StMulGh:   state_d = gbt_yaw_pkg::StSum;
      gbt_yaw_pkg::StSum: begin
        if (sum_go) begin
          state_d = gbt_yaw_pkg::StIdle;
        end
      end
      default: state_d = gbt_yaw_pkg::StIdle;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      gbt_yaw_pkg::StIdle: s_axis_tready_o = 1'b1;
      gbt_yaw_pkg::StBiasMul: begin
        mul_a = gbt_yaw_pkg::MulAW'(diff);
        mul_b = $signed({2'b00, alpha_q});
      end
      gbt_yaw_pkg::StMulDt: begin
        mul_a = gbt_yaw_pkg::MulAW'($signed(corr_q));
        mul_b = $signed({2'b00, dt_q});
      end
      gbt_yaw_pkg::StMulGl: begin
        mul_a = gbt_yaw_pkg::MulAW'($signed(prod_q[47:0]));
        mul_b = $signed({2'b00, gain_q[15:0]});
      end
      gbt_yaw_pkg::StMulGh: begin
        mul_a = gbt_yaw_pkg::MulAW'(p_q);
        mul_b = $signed({2'b00, gain_q[31:16]});
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbt_yaw_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= gbt_yaw_pkg::BiasAlphaRst;
      gain_q  <= gbt_yaw_pkg::RateGainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbt_yaw_pkg::RegBiasAlpha: alpha_q <= cfg_data_i[15:0];
        gbt_yaw_pkg::RegRateGain:  gain_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q      <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == gbt_yaw_pkg::StBiasAdd) begin
        bias_q <= bias_q + prod_q[47:16];
      end
      if (state_q == gbt_yaw_pkg::StSum && sum_go) begin
        heading_q   <= heading_q + inc;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= s_axis_tdata_i[15:0];
      dt_q     <= s_axis_tdata_i[31:16];
    end
    if (state_q == gbt_yaw_pkg::StCorr) begin
      corr_q <= corr_sat;
    end
    if (state_q == gbt_yaw_pkg::StMulGl) begin
      p_q <= $signed(prod_q[47:0]);
    end
    if (state_q == gbt_yaw_pkg::StMulGh) begin
      acc_q <= prod_q;
    end
    if (state_q == gbt_yaw_pkg::StBiasMul || state_q == gbt_yaw_pkg::StMulDt ||
        state_q == gbt_yaw_pkg::StMulGl || state_q == gbt_yaw_pkg::StMulGh) begin
      prod_q <= mul_p;
    end
    if (state_q == gbt_yaw_pkg::StSum && sum_go) begin
      out_data_q <= {bias_q, corr_q, heading_q + inc};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== src/gbt_yaw_chk.sv =====
`timescale 1ns / 1ps
`include "gyro_bias_tracking_yaw_integrator_macros.svh"

module gbt_yaw_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o
);

  // no result valid while in reset
  `GBT_YAW_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid_o, "valid during reset")

  // one item at a time: input closes right after a transaction
  `GBT_YAW_ASSERT(a_busy_after_take,
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "ready held after take")

  // a result never appears the cycle after its input
  `GBT_YAW_ASSERT(a_min_latency,
    (s_axis_tvalid_i && s_axis_tready_o) |=> !$rose(m_axis_tvalid_o), "result too early")

  // a stalled result holds
  `GBT_YAW_ASSERT(a_out_hold,
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)),
    "stalled result changed")

endmodule

bind gyro_bias_tracking_yaw_integrator gbt_yaw_chk u_gbt_yaw_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== sim/gyro_bias_tracking_yaw_integrator_tb.sv =====
`timescale 1ns / 1ps

module gyro_bias_tracking_yaw_integrator_tb;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [15:0]        dt_us;
    logic               still;
  } gyro_item_t;

  // packed from the top bit down: bias in [95:64], yaw in [31:0]
  typedef struct packed {
    logic [31:0] bias;
    logic [31:0] rate;
    logic [31:0] yaw;
  } heading_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [gbt_yaw_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [gbt_yaw_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [31:0]                      s_tdata = '0;   // gyro_sample, dt_us
  logic                             s_tuser = 1'b0; // stationary
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [95:0]                      m_tdata;        // yaw_angle, corrected_rate, bias_estimate

  gyro_bias_tracking_yaw_integrator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic signed [31:0] bias_q = '0;
  logic [31:0]        heading_q = '0;
  logic [15:0]        alpha_q = gbt_yaw_pkg::BiasAlphaRst;
  logic [31:0]        gain_q = gbt_yaw_pkg::RateGainRst;

  gyro_item_t gyro_q[$];
  heading_t   heading_exp_q[$];

  bit          quiet = 1'b0;
  bit          in_taken = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_still = 0;
  int unsigned n_sat = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;
  heading_t    got;
  heading_t    want;

  function automatic heading_t integrate_yaw(input gyro_item_t it);
    longint             s_fix;
    longint             bias_l;
    longint             corr_l;
    logic signed [127:0] rate_dt;
    logic signed [127:0] gain_x;
    logic signed [127:0] prod;
    heading_t           r;
    s_fix = longint'(it.sample) * 65536;
    bias_l = longint'(bias_q);
    if (it.still) begin
      bias_l = bias_l + ((longint'(alpha_q) * (s_fix - bias_l)) >>> 16);
      bias_q = bias_l[31:0];
      n_still++;
    end
    corr_l = s_fix - bias_l;
    // saturate the corrected rate before it is integrated
    if (corr_l > 64'sd2147483647) begin
      corr_l = 64'sd2147483647;
      n_sat++;
    end else if (corr_l < -64'sd2147483648) begin
      corr_l = -64'sd2147483648;
      n_sat++;
    end
    rate_dt = corr_l * longint'(it.dt_us);
    gain_x = {96'd0, gain_q};
    prod = (rate_dt * gain_x) >>> 48;
    heading_q = heading_q + prod[31:0];
    r.yaw = heading_q;
    r.rate = corr_l[31:0];
    r.bias = bias_q;
    return r;
  endfunction

  function automatic gyro_item_t random_gyro();
    gyro_item_t it;
    int         c;
    int unsigned kind;
    kind = $urandom_range(9);
    it.still = 1'($urandom_range(1));
    it.dt_us = 16'($urandom_range(65535));
    if (kind <= 2) begin
      it.sample = 16'($urandom_range(65535));
    end else if (kind <= 7) begin
      // stay close to the bias so the low-pass settles and tracks
      c = int'(bias_q >>> 16) + int'($urandom_range(64)) - 32;
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      it.sample = c[15:0];
      it.dt_us = 16'($urandom_range(2000));
      it.still = ($urandom_range(99) < 70);
    end else begin
      it.sample = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    return it;
  endfunction

  // sender: hold an offered transaction until accepted, then maybe idle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && !in_taken) begin
        s_tvalid <= 1'b1;
      end else if (gyro_q.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
        s_tvalid <= 1'b1;
        s_tdata <= {gyro_q[0].dt_us, gyro_q[0].sample};
        s_tuser <= gyro_q[0].still;
      end else begin
        s_tvalid <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      heading_exp_q.push_back(integrate_yaw(gyro_q.pop_front()));
      n_items++;
      in_taken = 1'b1;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done = hold_reqs;
      hold_left = HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      n_results++;
      if (heading_exp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        want = heading_exp_q.pop_front();
        if (got.bias !== want.bias) begin
          $display("%0t: bias_estimate expected %h actual %h", $time, want.bias, got.bias);
          errors++;
        end
        if (got.rate !== want.rate) begin
          $display("%0t: corrected_rate expected %h actual %h", $time, want.rate, got.rate);
          errors++;
        end
        if (got.yaw !== want.yaw) begin
          $display("%0t: yaw_angle expected %h actual %h", $time, want.yaw, got.yaw);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_gyro(input logic [15:0] sample, input logic [15:0] dt_us,
                           input logic still);
    gyro_q.push_back('{sample: sample, dt_us: dt_us, still: still});
  endtask

  task automatic drain();
    while (gyro_q.size() > 0 || heading_exp_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gbt_yaw_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == gbt_yaw_pkg::RegBiasAlpha) alpha_q = value[15:0];
    else gain_q = value;
    n_writes++;
  endtask

  task automatic random_phase(input int unsigned n, input bit stretch, input bit hold);
    quiet = stretch;
    repeat (n) gyro_q.push_back(random_gyro());
    if (hold) hold_reqs++;
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default gains: zero, full-scale samples, zero and maximum time
    push_gyro(16'sh0000, 16'd1000, 1'b0);
    push_gyro(16'sh7fff, 16'd65535, 1'b0);
    push_gyro(16'sh8000, 16'd65535, 1'b0);
    push_gyro(16'sh0083, 16'd0, 1'b1);
    push_gyro(16'sh0083, 16'd5000, 1'b1);
    push_gyro(16'shffff, 16'd1, 1'b1);
    push_gyro(16'sh7fff, 16'd2500, 1'b1);
    drain();

    // full alpha drags the bias to the rail, then the opposite rail overflows the rate
    write_reg(gbt_yaw_pkg::RegBiasAlpha, 32'h0000_ffff);
    write_reg(gbt_yaw_pkg::RegRateGain, 32'hffff_ffff);
    push_gyro(16'sh7fff, 16'd10, 1'b1);
    push_gyro(16'sh7fff, 16'd10, 1'b1);
    push_gyro(16'sh7fff, 16'd10, 1'b1);
    push_gyro(16'sh8000, 16'd65535, 1'b0);
    push_gyro(16'sh8000, 16'd10, 1'b1);
    push_gyro(16'sh8000, 16'd10, 1'b1);
    push_gyro(16'sh8000, 16'd10, 1'b1);
    push_gyro(16'sh7fff, 16'd65535, 1'b0);
    push_gyro(16'sh7fff, 16'd65535, 1'b1);
    drain();

    // zero gain leaves the heading alone
    write_reg(gbt_yaw_pkg::RegRateGain, 32'h0000_0000);
    push_gyro(16'sh1234, 16'd65535, 1'b0);
    push_gyro(16'sh8000, 16'd65535, 1'b1);
    drain();
    write_reg(gbt_yaw_pkg::RegBiasAlpha, 32'h0000_0000);
    push_gyro(16'sh7fff, 16'd65535, 1'b1);
    drain();

    write_reg(gbt_yaw_pkg::RegBiasAlpha, {16'd0, gbt_yaw_pkg::BiasAlphaRst});
    write_reg(gbt_yaw_pkg::RegRateGain, gbt_yaw_pkg::RateGainRst);
    random_phase(300, 1'b0, 1'b0);
    write_reg(gbt_yaw_pkg::RegBiasAlpha, $urandom_range(65535));
    write_reg(gbt_yaw_pkg::RegRateGain, $urandom);
    random_phase(300, 1'b1, 1'b0);
    write_reg(gbt_yaw_pkg::RegBiasAlpha, 32'h0000_ffff);
    write_reg(gbt_yaw_pkg::RegRateGain, 32'hffff_ffff);
    random_phase(300, 1'b0, 1'b1);
    write_reg(gbt_yaw_pkg::RegBiasAlpha, 32'h0000_0000);
    write_reg(gbt_yaw_pkg::RegRateGain, $urandom);
    random_phase(300, 1'b0, 1'b0);
    write_reg(gbt_yaw_pkg::RegBiasAlpha, 32'h0000_0001);
    write_reg(gbt_yaw_pkg::RegRateGain, 32'h0000_0001);
    random_phase(300, 1'b0, 1'b0);

    $display("run covered %0d gyro transactions (%0d stationary, %0d saturated rates)",
             n_items, n_still, n_sat);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             n_writes, n_results, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/gbt_yaw_pkg.sv
src/gyro_bias_tracking_yaw_integrator.sv
src/gbt_yaw_chk.sv
sim/gyro_bias_tracking_yaw_integrator_tb.sv
